[hw/rtl/i2cm_pkg.sv]
`default_nettype none

package i2cm_pkg;

  // field widths
  localparam int unsigned KindW  = 3;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned TickW  = 10;
  localparam int unsigned PhaseW = 5;

  // item kinds, also used as operation codes
  localparam logic [KindW-1:0] KIND_TICK  = 3'd0;
  localparam logic [KindW-1:0] KIND_START = 3'd1;
  localparam logic [KindW-1:0] KIND_STOP  = 3'd2;
  localparam logic [KindW-1:0] KIND_WRITE = 3'd3;
  localparam logic [KindW-1:0] KIND_READ  = 3'd4;

  // operation codes for the engine state
  localparam logic [KindW-1:0] OP_IDLE  = KIND_TICK;
  localparam logic [KindW-1:0] OP_START = KIND_START;
  localparam logic [KindW-1:0] OP_STOP  = KIND_STOP;
  localparam logic [KindW-1:0] OP_WRITE = KIND_WRITE;
  localparam logic [KindW-1:0] OP_READ  = KIND_READ;

  // phase counts per sequence
  localparam int unsigned NumBits = 8;
  localparam logic [PhaseW-1:0] START_PHASES = PhaseW'(4);
  localparam logic [PhaseW-1:0] STOP_PHASES  = PhaseW'(3);
  localparam logic [PhaseW-1:0] WRITE_PHASES = PhaseW'(NumBits * 3 + 3);
  localparam logic [PhaseW-1:0] READ_PHASES  = PhaseW'(1 + NumBits * 2 + 3);

  // landmark phases of write and read
  localparam logic [PhaseW-1:0] WR_ACK_SDA = PhaseW'(NumBits * 3);
  localparam logic [PhaseW-1:0] WR_ACK_SCL = PhaseW'(NumBits * 3 + 1);
  localparam logic [PhaseW-1:0] RD_BITS_END = PhaseW'(NumBits * 2);
  localparam logic [PhaseW-1:0] RD_ACK_SDA  = PhaseW'(NumBits * 2 + 1);
  localparam logic [PhaseW-1:0] RD_ACK_SCL  = PhaseW'(NumBits * 2 + 2);

  // sub-phase codes within one written bit
  localparam logic [1:0] SUB_DATA = 2'd0;
  localparam logic [1:0] SUB_HIGH = 2'd1;
  localparam logic [1:0] SUB_LOW  = 2'd2;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [ByteW-1:0] tx_byte;
    logic             ack_level;
    logic             sda_in;
  } item_t;

  typedef struct packed {
    logic             scl_level;
    logic             sda_level;
    logic             busy_res;
    logic             done_res;
    logic [ByteW-1:0] rx_byte;
    logic             ack_seen;
    logic             rejected;
  } result_t;

  // number of phases of an operation
  function automatic logic [PhaseW-1:0] phase_total(input logic [KindW-1:0] op);
    logic [PhaseW-1:0] total;
    case (op)
      OP_START: total = START_PHASES;
      OP_STOP:  total = STOP_PHASES;
      OP_WRITE: total = WRITE_PHASES;
      OP_READ:  total = READ_PHASES;
      default:  total = '0;
    endcase
    return total;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/i2cm_if.sv]
`default_nettype none

// command and tick channel
interface i2cm_in_if import i2cm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [ByteW-1:0] tx_byte;
  logic             ack_level;
  logic             sda_in;

  modport source (output valid, kind, tx_byte, ack_level, sda_in, input ready);
  modport sink   (input valid, kind, tx_byte, ack_level, sda_in, output ready);
endinterface

// line level and status channel
interface i2cm_out_if import i2cm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             scl_level;
  logic             sda_level;
  logic             busy_res;
  logic             done_res;
  logic [ByteW-1:0] rx_byte;
  logic             ack_seen;
  logic             rejected;

  modport source (output valid, scl_level, sda_level, busy_res, done_res, rx_byte,
                  ack_seen, rejected, input ready);
  modport sink   (input valid, scl_level, sda_level, busy_res, done_res, rx_byte,
                  ack_seen, rejected, output ready);
endinterface

`default_nettype wire

[hw/rtl/i2c_master_byte_engine_core.sv]
// I2C master byte engine. Each transaction on in_i is either a command (start, stop,
// write byte, read byte) or a tick that carries the sampled data line; every transaction
// yields exactly one transaction on out_o with the driven clock and data levels (1 means
// released high), busy, done, the read byte, the raw acknowledge level seen on a write
// and a flag for a command ignored while busy. A phase lasts cfg_wdata_i ticks as last
// written through cfg_we_i (zero acts as one, reset value one); configuration should be
// written only while idle. The block takes one transaction per clock while out_o is ready:
// an input register and a result register surround the state update, so a transaction
// passes the input register and then the result register, and both sides may stall freely.
`default_nettype none

module i2c_master_byte_engine_core import i2cm_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [TickW-1:0] cfg_wdata_i,
  i2cm_in_if.sink               in_i,
  i2cm_out_if.source            out_o
);

  item_t   in_item, stage_item;
  logic    stage_valid, take;
  logic    res_valid;
  result_t res;

  // pack the input transaction
  always_comb begin
    in_item.kind      = in_i.kind;
    in_item.tx_byte   = in_i.tx_byte;
    in_item.ack_level = in_i.ack_level;
    in_item.sda_in    = in_i.sda_in;
  end

  i2cm_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .in_item_i    (in_item),
    .take_i       (take),
    .item_valid_o (stage_valid),
    .item_o       (stage_item)
  );

  i2cm_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_valid_i (stage_valid),
    .item_i       (stage_item),
    .take_o       (take),
    .res_valid_o  (res_valid),
    .res_ready_i  (out_o.ready),
    .res_o        (res)
  );

  // unpack the result transaction
  assign out_o.valid     = res_valid;
  assign out_o.scl_level = res.scl_level;
  assign out_o.sda_level = res.sda_level;
  assign out_o.busy_res  = res.busy_res;
  assign out_o.done_res  = res.done_res;
  assign out_o.rx_byte   = res.rx_byte;
  assign out_o.ack_seen  = res.ack_seen;
  assign out_o.rejected  = res.rejected;

endmodule

`default_nettype wire

[hw/rtl/i2cm_in_stage.sv]
`default_nettype none

module i2cm_in_stage import i2cm_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output      logic  in_ready_o,
  input  wire item_t in_item_i,
  input  wire logic  take_i,
  output      logic  item_valid_o,
  output      item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q;

  // accept when empty or when the held item moves on this cycle
  assign in_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

`default_nettype wire

[hw/rtl/i2cm_engine.sv]
`default_nettype none

module i2cm_engine import i2cm_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [TickW-1:0] cfg_wdata_i,
  input  wire logic             item_valid_i,
  input  wire item_t            item_i,
  output      logic             take_o,
  output      logic             res_valid_o,
  input  wire logic             res_ready_i,
  output      result_t          res_o
);

  logic [TickW-1:0]  tpp_q;
  logic [KindW-1:0]  op_q, op_d;
  logic [PhaseW-1:0] ph_q, ph_d;
  logic [TickW-1:0]  cnt_q, cnt_d;
  logic [1:0]        sub_q, sub_d;
  logic [ByteW-1:0]  tx_q, tx_d;
  logic [ByteW-1:0]  rx_q, rx_d;
  logic              ackd_q, ackd_d;
  logic              acks_q, acks_d;
  logic              scl_q, scl_d;
  logic              sda_q, sda_d;
  logic              done, rej;
  logic              res_valid_q;
  result_t           res_q;

  logic              busy, is_cmd;
  logic [TickW-1:0]  limit, cnt_inc;
  logic [PhaseW-1:0] ph_n;
  logic [1:0]        sub_n;

  // result register moves on when empty or drained
  assign take_o = item_valid_i && (!res_valid_q || res_ready_i);

  assign busy    = (op_q != OP_IDLE);
  assign limit   = (tpp_q == '0) ? TickW'(1) : tpp_q;
  assign cnt_inc = cnt_q + TickW'(1);
  assign ph_n    = ph_q + PhaseW'(1);
  assign sub_n   = (sub_q == SUB_LOW) ? SUB_DATA : sub_q + 2'd1;

  // next state for one item
  always_comb begin
    op_d   = op_q;
    ph_d   = ph_q;
    cnt_d  = cnt_q;
    sub_d  = sub_q;
    tx_d   = tx_q;
    rx_d   = rx_q;
    ackd_d = ackd_q;
    acks_d = acks_q;
    scl_d  = scl_q;
    sda_d  = sda_q;
    done   = 1'b0;
    rej    = 1'b0;
    is_cmd = item_i.kind inside {[KIND_START:KIND_READ]};

    if (is_cmd) begin
      if (busy) begin
        rej = 1'b1;
      end else begin
        op_d  = item_i.kind;
        ph_d  = '0;
        cnt_d = '0;
        sub_d = SUB_DATA;
        // levels of phase zero
        case (item_i.kind)
          KIND_START: sda_d = 1'b1;
          KIND_STOP:  sda_d = 1'b0;
          KIND_WRITE: begin
            sda_d = item_i.tx_byte[ByteW-1];
            tx_d  = {item_i.tx_byte[ByteW-2:0], 1'b0};
          end
          KIND_READ: begin
            rx_d   = '0;
            ackd_d = item_i.ack_level;
            sda_d  = 1'b1;
          end
          default: ;
        endcase
      end
    end else if (item_i.kind == KIND_TICK && busy) begin
      if (cnt_inc >= limit) begin
        cnt_d = '0;
        // sample on the tick that ends a sampling phase
        if (op_q == OP_WRITE && ph_q == WR_ACK_SCL) begin
          acks_d = item_i.sda_in;
        end else if (op_q == OP_READ && ph_q[0] && ph_q < RD_BITS_END) begin
          rx_d = {rx_q[ByteW-2:0], item_i.sda_in};
        end
        if (ph_n >= phase_total(op_q)) begin
          op_d = OP_IDLE;
          ph_d = '0;
          done = 1'b1;
        end else begin
          ph_d  = ph_n;
          sub_d = sub_n;
          // levels set on entering the next phase
          case (op_q)
            OP_START: begin
              if (ph_n == PhaseW'(1)) begin
                scl_d = 1'b1;
              end else if (ph_n == PhaseW'(2)) begin
                sda_d = 1'b0;
              end else begin
                scl_d = 1'b0;
              end
            end
            OP_STOP: begin
              if (ph_n == PhaseW'(1)) begin
                scl_d = 1'b1;
              end else begin
                sda_d = 1'b1;
              end
            end
            OP_WRITE: begin
              if (ph_n < WR_ACK_SDA) begin
                case (sub_n)
                  SUB_DATA: begin
                    sda_d = tx_q[ByteW-1];
                    tx_d  = {tx_q[ByteW-2:0], 1'b0};
                  end
                  SUB_HIGH: scl_d = 1'b1;
                  default:  scl_d = 1'b0;
                endcase
              end else if (ph_n == WR_ACK_SDA) begin
                sda_d = 1'b1;
              end else if (ph_n == WR_ACK_SCL) begin
                scl_d = 1'b1;
              end else begin
                scl_d = 1'b0;
              end
            end
            OP_READ: begin
              if (ph_n <= RD_BITS_END) begin
                scl_d = ph_n[0];
              end else if (ph_n == RD_ACK_SDA) begin
                sda_d = ackd_q;
              end else if (ph_n == RD_ACK_SCL) begin
                scl_d = 1'b1;
              end else begin
                scl_d = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end else begin
        cnt_d = cnt_inc;
      end
    end
  end

  // engine state and configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpp_q  <= TickW'(1);
      op_q   <= OP_IDLE;
      ph_q   <= '0;
      cnt_q  <= '0;
      sub_q  <= SUB_DATA;
      tx_q   <= '0;
      rx_q   <= '0;
      ackd_q <= 1'b1;
      acks_q <= 1'b1;
      scl_q  <= 1'b1;
      sda_q  <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        tpp_q <= cfg_wdata_i;
      end
      if (take_o) begin
        op_q   <= op_d;
        ph_q   <= ph_d;
        cnt_q  <= cnt_d;
        sub_q  <= sub_d;
        tx_q   <= tx_d;
        rx_q   <= rx_d;
        ackd_q <= ackd_d;
        acks_q <= acks_d;
        scl_q  <= scl_d;
        sda_q  <= sda_d;
      end
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (take_o) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (take_o) begin
      res_q.scl_level <= scl_d;
      res_q.sda_level <= sda_d;
      res_q.busy_res  <= (op_d != OP_IDLE);
      res_q.done_res  <= done;
      res_q.rx_byte   <= rx_d;
      res_q.ack_seen  <= acks_d;
      res_q.rejected  <= rej;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire
